[src/assert_macros.svh]
// Assertion macros shared by the brush stamp RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("implication check failed");
`define ASSERT_NEVER(lbl, ck, rn, a) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(a)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(lbl, ck, rn, a, c)
`define ASSERT_NEVER(lbl, ck, rn, a)
`endif
`endif

[src/cbs_pkg.sv]
// Types and constants for the circular brush stamp
package cbs_pkg;

    // signed scan offset, wide enough for -3..3
    localparam int OFS_W = 4;

    // register map (word index)
    localparam logic [2:0] REG_BRUSH  = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_RED    = 3'd3;
    localparam logic [2:0] REG_GREEN  = 3'd4;
    localparam logic [2:0] REG_BLUE   = 3'd5;
    localparam logic [2:0] REG_ALPHA  = 3'd6;

    // reset values
    localparam logic [2:0]  RST_BRUSH  = 3'd5;
    localparam logic [12:0] RST_WIDTH  = 13'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [7:0]  RST_RED    = 8'd255;
    localparam logic [7:0]  RST_GREEN  = 8'd0;
    localparam logic [7:0]  RST_BLUE   = 8'd0;
    localparam logic [7:0]  RST_ALPHA  = 8'd255;

    // one queued dot: centre and saturated radius
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [1:0]         radius;
    } dot_t;

    // effective image settings seen by the back end
    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [31:0] word;
    } cfg_t;

endpackage

[src/cbs_front.sv]
// Front end: accepts dot words, fixes the radius, holds them in a two-entry queue
module cbs_front #(
    parameter int MAX_RADIUS = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [15:0]  center_x,
    input  logic signed [15:0]  center_y,
    input  logic [2:0]          brush_size,
    input  logic                pop,
    output logic                busy,
    output logic                head_valid,
    output cbs_pkg::dot_t       head
);

    localparam logic [1:0] RAD_MAX = 2'(MAX_RADIUS);

    cbs_pkg::dot_t queue_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          push;
    logic [1:0]    radius;
    cbs_pkg::dot_t entry;

    // radius is half the brush setting, saturated
    always_comb
    begin
        radius = brush_size[2:1];
        if (radius > RAD_MAX)
        begin
            radius = RAD_MAX;
        end
        entry.cx     = center_x;
        entry.cy     = center_y;
        entry.radius = radius;
    end

    assign busy       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign push       = start && !busy;
    assign head       = queue_mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

[src/cbs_back.sv]
// Back end: scans the disc offsets and produces the pixel writes
module cbs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  cbs_pkg::dot_t       head,
    input  cbs_pkg::cfg_t       cfg,
    output logic                pop,
    output logic                strobe,
    output logic [11:0]         pixel_x,
    output logic [11:0]         pixel_y,
    output logic [25:0]         byte_offset,
    output logic [31:0]         pixel_word,
    output logic                last_write
);

    localparam int OW = cbs_pkg::OFS_W;

    // clamp a coordinate into 0 .. dim-1
    function automatic logic [11:0] clamp_coord(input logic signed [16:0] v,
                                                input logic [12:0] dim);
        logic [12:0] lim;
        begin
            lim = dim - 13'd1;
            if (v[16])
            begin
                clamp_coord = 12'd0;
            end
            else if (v[15:0] >= {3'b000, dim})
            begin
                clamp_coord = lim[11:0];
            end
            else
            begin
                clamp_coord = v[11:0];
            end
        end
    endfunction

    logic                   active_reg, active_next;
    logic signed [15:0]     cx_reg, cy_reg;
    logic signed [OW-1:0]   r_reg, dx_reg, dy_reg;
    logic signed [OW-1:0]   r_new, dx_next, dy_next;
    logic signed [2*OW-1:0] sq_x, sq_y, sq_r;
    logic [2*OW:0]          sum_sq;
    logic                   in_disc, last_pt, done;

    logic                   s1_valid_reg, s1_last_reg;
    logic [11:0]            s1_x_reg, s1_y_reg;
    logic                   s2_valid_reg, s2_last_reg;
    logic [11:0]            s2_x_reg;
    logic [24:0]            s2_prod_reg;
    logic [24:0]            addr_pix;

    logic                   strobe_reg, last_reg;
    logic [11:0]            px_reg, py_reg, s2_y_reg;
    logic [25:0]            off_reg;
    logic [31:0]            word_reg;

    // disc test and end of scan
    always_comb
    begin
        sq_x    = dx_reg * dx_reg;
        sq_y    = dy_reg * dy_reg;
        sq_r    = r_reg * r_reg;
        sum_sq  = {1'b0, sq_x} + {1'b0, sq_y};
        in_disc = (sum_sq <= {1'b0, sq_r});
        last_pt = (dy_reg == r_reg) && (dx_reg == '0);
        done    = !active_reg || last_pt;
        pop     = done && head_valid;
        r_new   = OW'(signed'({1'b0, head.radius}));
    end

    // scan counters: dy outer, dx inner
    always_comb
    begin
        active_next = active_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        if (pop)
        begin
            active_next = 1'b1;
            dx_next     = -r_new;
            dy_next     = -r_new;
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
        else if (dx_reg == r_reg)
        begin
            dx_next = -r_reg;
            dy_next = dy_reg + OW'(1);
        end
        else
        begin
            dx_next = dx_reg + OW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            s1_valid_reg <= active_reg && in_disc;
            s2_valid_reg <= s1_valid_reg;
            strobe_reg   <= s2_valid_reg;
        end
    end

    // dot and counter payload
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        if (pop)
        begin
            cx_reg <= head.cx;
            cy_reg <= head.cy;
            r_reg  <= r_new;
        end
    end

    // stage 1: clamp the point into the image
    always_ff @(posedge clk)
    begin
        s1_x_reg    <= clamp_coord(17'(cx_reg) + 17'(dx_reg), cfg.width);
        s1_y_reg    <= clamp_coord(17'(cy_reg) + 17'(dy_reg), cfg.height);
        s1_last_reg <= last_pt;
    end

    // stage 2: row times stride
    always_ff @(posedge clk)
    begin
        s2_prod_reg <= {13'd0, s1_y_reg} * {12'd0, cfg.width};
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_last_reg <= s1_last_reg;
    end

    // stage 3: byte address and output register
    assign addr_pix = s2_prod_reg + {13'd0, s2_x_reg};

    always_ff @(posedge clk)
    begin
        px_reg   <= s2_x_reg;
        py_reg   <= s2_y_reg;
        off_reg  <= {addr_pix[23:0], 2'b00};
        word_reg <= cfg.word;
        last_reg <= s2_last_reg;
    end

    assign strobe      = strobe_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign byte_offset = off_reg;
    assign pixel_word  = word_reg;
    assign last_write  = strobe_reg && last_reg;

endmodule

[src/circular_brush_stamp_core.sv]
// Circular brush stamp: filled-disc pixel writer with APB register port
// On an idle block the first write of a dot passes the queue, the scan counter registers,
// the stage 1 and stage 2 registers and the output register. The scan counter steps one
// offset per cycle, popping the next dot at the last offset; one write per cycle at most.
// A two-entry queue takes further dots while a scan runs; busy is high when it is full.
// Reset clears the queue, scan and output strobe and loads the registers' defaults.
`include "assert_macros.svh"

module circular_brush_stamp_core #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_DIM    = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    // dot input
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  center_x,
    input  logic signed [15:0]  center_y,
    // pixel writes
    output logic                strobe,
    output logic [11:0]         pixel_x,
    output logic [11:0]         pixel_y,
    output logic [25:0]         byte_offset,
    output logic [31:0]         pixel_word,
    output logic                last_write,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [12:0] DIM_LIM = 13'(MAX_DIM);

    logic [2:0]     brush_reg;
    logic [12:0]    width_reg, height_reg;
    logic [7:0]     red_reg, green_reg, blue_reg, alpha_reg;
    logic           wr_en;
    logic [2:0]     reg_idx;
    cbs_pkg::cfg_t  cfg;
    cbs_pkg::dot_t  head;
    logic           head_valid, pop;

    // effective image size: zero acts as one, capped at the maximum
    function automatic logic [12:0] eff_dim(input logic [12:0] d);
        begin
            if (d == 13'd0)
            begin
                eff_dim = 13'd1;
            end
            else if (d > DIM_LIM)
            begin
                eff_dim = DIM_LIM;
            end
            else
            begin
                eff_dim = d;
            end
        end
    endfunction

    // register writes
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_reg  <= cbs_pkg::RST_BRUSH;
            width_reg  <= cbs_pkg::RST_WIDTH;
            height_reg <= cbs_pkg::RST_HEIGHT;
            red_reg    <= cbs_pkg::RST_RED;
            green_reg  <= cbs_pkg::RST_GREEN;
            blue_reg   <= cbs_pkg::RST_BLUE;
            alpha_reg  <= cbs_pkg::RST_ALPHA;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                cbs_pkg::REG_BRUSH:  brush_reg  <= pwdata[2:0];
                cbs_pkg::REG_WIDTH:  width_reg  <= pwdata[12:0];
                cbs_pkg::REG_HEIGHT: height_reg <= pwdata[12:0];
                cbs_pkg::REG_RED:    red_reg    <= pwdata[7:0];
                cbs_pkg::REG_GREEN:  green_reg  <= pwdata[7:0];
                cbs_pkg::REG_BLUE:   blue_reg   <= pwdata[7:0];
                cbs_pkg::REG_ALPHA:  alpha_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_idx)
            cbs_pkg::REG_BRUSH:  prdata = {29'd0, brush_reg};
            cbs_pkg::REG_WIDTH:  prdata = {19'd0, width_reg};
            cbs_pkg::REG_HEIGHT: prdata = {19'd0, height_reg};
            cbs_pkg::REG_RED:    prdata = {24'd0, red_reg};
            cbs_pkg::REG_GREEN:  prdata = {24'd0, green_reg};
            cbs_pkg::REG_BLUE:   prdata = {24'd0, blue_reg};
            cbs_pkg::REG_ALPHA:  prdata = {24'd0, alpha_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // settings for the scanner
    always_comb
    begin
        cfg.width  = eff_dim(width_reg);
        cfg.height = eff_dim(height_reg);
        cfg.word   = {alpha_reg, red_reg, green_reg, blue_reg};
    end

    cbs_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .center_x   (center_x),
        .center_y   (center_y),
        .brush_size (brush_reg),
        .pop        (pop),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head)
    );

    cbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .cfg         (cfg),
        .pop         (pop),
        .strobe      (strobe),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .byte_offset (byte_offset),
        .pixel_word  (pixel_word),
        .last_write  (last_write)
    );

    // checks
    `ASSERT_IMPLIES(a_pix_in_image, clk, rst_n, strobe,
        ({1'b0, pixel_x} < cfg.width) && ({1'b0, pixel_y} < cfg.height))
    `ASSERT_NEVER(a_last_without_strobe, clk, rst_n, last_write && !strobe)
    `ASSERT_IMPLIES(a_word_matches, clk, rst_n, strobe, pixel_word == cfg.word)
    `ASSERT_NEVER(a_pop_when_empty, clk, rst_n, pop && !head_valid)

endmodule
